>>> hdl/msk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types and constants of the MSK bit frame modulator: CORDIC widths,
// arctangent table, register indexes and the sideband tag of a sample.
// ----------------------------------------------------------------------------
package msk_pkg;

  localparam int CORDIC_ITERS = 24;
  localparam int XY_W         = 34;
  localparam int Z_W          = 32;
  localparam int RES_W        = 30;
  localparam int ANGLE_W      = 32;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CARRIER_STEP    = 3'd0,
    REG_DEVIATION_STEP  = 3'd1,
    REG_SAMPLES_PER_BIT = 3'd2,
    REG_FRAME_BITS      = 3'd3,
    REG_START_QUADRANT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic frame_end;
    logic bit_sent;
  } msk_tag_t;

endpackage
`default_nettype wire

>>> hdl/msk_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msk_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module msk_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/msk_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msk_cordic
// Pipelined rotation-mode CORDIC cosine, one iteration per stage, followed
// by a quadrant fold, rounding and saturation stage. All stages move on en.
// ----------------------------------------------------------------------------
module msk_cordic #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [msk_pkg::ANGLE_W-1:0]   angle,
  input  msk_pkg::msk_tag_t             in_tag,
  output logic                          out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] sample,
  output msk_pkg::msk_tag_t             out_tag
);

  import msk_pkg::*;

  localparam int SH = RES_W - (SAMPLE_WIDTH - 1);
  localparam logic signed [XY_W-1:0] HALF = XY_W'(1 << (SH - 1));
  localparam logic signed [XY_W-1:0] LIM  = XY_W'((1 << (SAMPLE_WIDTH - 1)) - 1);

  logic                   st_v [CORDIC_ITERS];
  logic signed [XY_W-1:0] st_x [CORDIC_ITERS];
  logic signed [XY_W-1:0] st_y [CORDIC_ITERS];
  logic signed [Z_W-1:0]  st_z [CORDIC_ITERS];
  logic [1:0]             st_q [CORDIC_ITERS];
  msk_tag_t               st_t [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
    logic                   sv;
    logic signed [XY_W-1:0] sx, sy, nx, ny;
    logic signed [Z_W-1:0]  sz, nz;
    logic [1:0]             sq;
    msk_tag_t               stag;

    if (i == 0) begin : g_first
      assign sv   = in_valid;
      assign sx   = CORDIC_X0;
      assign sy   = '0;
      assign sz   = $signed({2'b00, angle[RES_W-1:0]});
      assign sq   = angle[ANGLE_W-1 -: 2];
      assign stag = in_tag;
    end else begin : g_next
      assign sv   = st_v[i-1];
      assign sx   = st_x[i-1];
      assign sy   = st_y[i-1];
      assign sz   = st_z[i-1];
      assign sq   = st_q[i-1];
      assign stag = st_t[i-1];
    end

    always_comb begin
      if (!sz[Z_W-1]) begin
        nx = sx - (sy >>> i);
        ny = sy + (sx >>> i);
        nz = sz - ATAN_TURNS[i];
      end else begin
        nx = sx + (sy >>> i);
        ny = sy - (sx >>> i);
        nz = sz + ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_x[i] <= nx;
        st_y[i] <= ny;
        st_z[i] <= nz;
        st_q[i] <= sq;
        st_t[i] <= stag;
      end
    end
  end

  logic signed [XY_W-1:0] folded;
  logic signed [XY_W-1:0] rounded;
  logic signed [XY_W-1:0] clipped;

  always_comb begin
    unique case (st_q[CORDIC_ITERS-1])
      2'd0:    folded = st_x[CORDIC_ITERS-1];
      2'd1:    folded = -st_y[CORDIC_ITERS-1];
      2'd2:    folded = -st_x[CORDIC_ITERS-1];
      default: folded = st_y[CORDIC_ITERS-1];
    endcase
    rounded = (folded + HALF) >>> SH;
    if (rounded > LIM) begin
      clipped = LIM;
    end else if (rounded < -LIM) begin
      clipped = -LIM;
    end else begin
      clipped = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_v[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample  <= clipped[SAMPLE_WIDTH-1:0];
      out_tag <= st_t[CORDIC_ITERS-1];
    end
  end

endmodule
`default_nettype wire

>>> hdl/msk_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msk_skid
// Two-entry output buffer. The pipeline keeps moving while one finished item
// waits; it holds only when both entries are full and the sink stalls.
// ----------------------------------------------------------------------------
module msk_skid #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         stall,
  output logic         valid,
  output logic [W-1:0] dout,
  output logic         full
);

  logic         v0, v1, v0_next, v1_next;
  logic         load_e0, load_e1, shift_e1;
  logic [W-1:0] e1;
  logic         pop;

  assign pop   = v0 && !stall;
  assign valid = v0;
  assign full  = v1;

  always_comb begin
    v0_next  = v0;
    v1_next  = v1;
    load_e0  = 1'b0;
    load_e1  = 1'b0;
    shift_e1 = 1'b0;
    if (pop) begin
      if (v1) begin
        shift_e1 = 1'b1;
        v1_next  = push;
        load_e1  = push;
      end else begin
        v0_next = push;
        load_e0 = push;
      end
    end else if (push) begin
      if (v0) begin
        v1_next = 1'b1;
        load_e1 = 1'b1;
      end else begin
        v0_next = 1'b1;
        load_e0 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_e1) begin
      dout <= e1;
    end else if (load_e0) begin
      dout <= din;
    end
    if (load_e1) begin
      e1 <= din;
    end
  end

endmodule
`default_nettype wire

>>> hdl/msk_bit_frame_modulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msk_bit_frame_modulator
// MSK modulator that plays a frame of bits held in a RAM. Load items write
// the frame, tick items produce one cosine sample of the carrier phase.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_stall       mode, bit_index, bit_value
//   out      source     out_valid / out_stall     sample, frame_end, bit_sent
//   cfg      sink       cfg_write                 cfg_index, cfg_data
//
// One item is taken per clock while in_stall is low. The phase loop reads the
// frame bit from the RAM, registered, then adds the step to the phase register.
// Reset is synchronous; the frame RAM is not cleared and must be loaded.
// The pipeline holds only while both output buffer entries are full and
// out_stall is high.
// ----------------------------------------------------------------------------
module msk_bit_frame_modulator #(
  parameter int MAX_FRAME_BITS = 4096,
  parameter int PHASE_WIDTH    = 32,
  parameter int SAMPLE_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [11:0]                      bit_index,
  input  logic                             bit_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   sample,
  output logic                             frame_end,
  output logic                             bit_sent,
  input  logic                             cfg_write,
  input  logic [msk_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [msk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import msk_pkg::*;

  localparam int AW     = (MAX_FRAME_BITS > 1) ? $clog2(MAX_FRAME_BITS) : 1;
  localparam int FB_MAX = (MAX_FRAME_BITS < 8191) ? MAX_FRAME_BITS : 8191;
  localparam int POS_W  = (FB_MAX > 1) ? $clog2(FB_MAX) : 1;
  localparam int CW0    = $clog2(MAX_FRAME_BITS + 1);
  localparam int CNT_W  = ((CW0 > 13) ? CW0 : 13) + 1;
  localparam int PW     = PHASE_WIDTH;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  function automatic logic [AW-1:0] wrap_index(input logic [11:0] idx);
    logic [11:0]    r;
    logic [AW+11:0] r_wide;
    r = idx;
    for (int k = 11; k >= 0; k--) begin
      if ((longint'(MAX_FRAME_BITS) << k) <= 64'd4095) begin
        if (r >= 12'(longint'(MAX_FRAME_BITS) << k)) begin
          r = r - 12'(longint'(MAX_FRAME_BITS) << k);
        end
      end
    end
    r_wide = {{AW{1'b0}}, r};
    return r_wide[AW-1:0];
  endfunction

  // Configuration registers.
  logic [31:0] carrier_step;
  logic [30:0] deviation_step;
  logic [8:0]  samples_per_bit;
  logic [12:0] frame_bits;

  // Play position and phase.
  logic [POS_W-1:0] bit_position, bit_position_next;
  logic [7:0]       sample_in_bit, sample_in_bit_next;
  logic [PW-1:0]    phase;
  logic             pos_wrap;

  logic en, accept, skid_full;
  logic s1_valid, s1_frame_end, s1_bit;

  assign en       = !(skid_full && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step    <= '0;
      deviation_step  <= 31'd67108864;
      samples_per_bit <= 9'd16;
      frame_bits      <= 13'd1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CARRIER_STEP:    carrier_step    <= cfg_data;
        REG_DEVIATION_STEP:  deviation_step  <= cfg_data[30:0];
        REG_SAMPLES_PER_BIT: samples_per_bit <= cfg_data[8:0];
        REG_FRAME_BITS:      frame_bits      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Position stepping.
  logic [8:0]       spb_lim, sib_inc;
  logic [CNT_W-1:0] fb_lim, pos_inc;

  always_comb begin
    if (samples_per_bit == 9'd0) begin
      spb_lim = 9'd1;
    end else if (samples_per_bit > 9'd256) begin
      spb_lim = 9'd256;
    end else begin
      spb_lim = samples_per_bit;
    end
    if (frame_bits == 13'd0) begin
      fb_lim = CNT_W'(1);
    end else if (CNT_W'(frame_bits) > CNT_W'(MAX_FRAME_BITS)) begin
      fb_lim = CNT_W'(MAX_FRAME_BITS);
    end else begin
      fb_lim = CNT_W'(frame_bits);
    end
    sib_inc = {1'b0, sample_in_bit} + 9'd1;
    pos_inc = CNT_W'(bit_position) + CNT_W'(1);
  end

  always_comb begin
    sample_in_bit_next = sample_in_bit;
    bit_position_next  = bit_position;
    pos_wrap           = 1'b0;
    if (accept) begin
      if (mode == MODE_LOAD) begin
        sample_in_bit_next = '0;
        bit_position_next  = '0;
      end else if (sib_inc >= spb_lim) begin
        sample_in_bit_next = '0;
        if (pos_inc >= fb_lim) begin
          bit_position_next = '0;
          pos_wrap          = 1'b1;
        end else begin
          bit_position_next = pos_inc[POS_W-1:0];
        end
      end else begin
        sample_in_bit_next = sib_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position  <= '0;
      sample_in_bit <= '0;
    end else begin
      bit_position  <= bit_position_next;
      sample_in_bit <= sample_in_bit_next;
    end
  end

  // Frame store.
  logic [AW+POS_W-1:0] rd_wide;
  logic [AW-1:0]       rd_addr;

  assign rd_wide = {{AW{1'b0}}, bit_position};
  assign rd_addr = rd_wide[AW-1:0];

  msk_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FRAME_BITS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (accept && mode == MODE_LOAD),
    .waddr (wrap_index(bit_index)),
    .wdata (bit_value),
    .re    (en),
    .raddr (rd_addr),
    .rdata (s1_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && mode == MODE_TICK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frame_end <= pos_wrap;
    end
  end

  // Phase accumulator.
  logic [PW+31:0] carrier_wide, dev_wide, phase_ext;
  logic [PW-1:0]  phase_up, phase_down;
  logic [PW-1:0]  preset;

  assign carrier_wide = {{PW{1'b0}}, carrier_step};
  assign dev_wide     = {{(PW + 1){1'b0}}, deviation_step};
  assign phase_up     = phase + carrier_wide[PW-1:0] + dev_wide[PW-1:0];
  assign phase_down   = phase + carrier_wide[PW-1:0] - dev_wide[PW-1:0];
  assign preset       = {cfg_data[1:0], {(PW - 2){1'b0}}};
  assign phase_ext    = {phase, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cfg_write && cfg_reg_t'(cfg_index) == REG_START_QUADRANT) begin
      phase <= preset;
    end else if (en && s1_valid) begin
      phase <= s1_bit ? phase_up : phase_down;
    end
  end

  // Cosine pipeline and output buffer.
  msk_tag_t                       s1_tag, cos_tag;
  logic                           cos_valid;
  logic signed [SAMPLE_WIDTH-1:0] cos_sample;

  assign s1_tag.frame_end = s1_frame_end;
  assign s1_tag.bit_sent  = s1_bit;

  msk_cordic #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .angle     (phase_ext[PW+31 -: ANGLE_W]),
    .in_tag    (s1_tag),
    .out_valid (cos_valid),
    .sample    (cos_sample),
    .out_tag   (cos_tag)
  );

  logic [SAMPLE_WIDTH+1:0] skid_out;

  msk_skid #(
    .W (SAMPLE_WIDTH + 2)
  ) u_skid (
    .clk   (clk),
    .rst   (rst),
    .push  (en && cos_valid),
    .din   ({cos_sample, cos_tag.frame_end, cos_tag.bit_sent}),
    .stall (out_stall),
    .valid (out_valid),
    .dout  (skid_out),
    .full  (skid_full)
  );

  assign sample    = skid_out[SAMPLE_WIDTH+1:2];
  assign frame_end = skid_out[1];
  assign bit_sent  = skid_out[0];

`ifndef SYNTHESIS
  a_load_rewinds: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_LOAD |=> bit_position == '0 && sample_in_bit == '0)
    else $error("load item did not rewind the play position");

  a_tick_reads: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_TICK |=> s1_valid)
    else $error("tick item did not enter the read stage");

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !en && !cfg_write |=> $stable(phase))
    else $error("phase moved while the pipeline was held");

  a_wrap_tagged: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_TICK && pos_wrap |=> s1_frame_end)
    else $error("frame wrap not marked on its item");
`endif

endmodule
`default_nettype wire
